@@ sv/e2cd_pkg.sv @@
// shared widths, word layout and month table for the epoch to civil datetime converter
package e2cd_pkg;

    localparam int unsigned SECS_W   = 48;
    localparam int unsigned YEAR_W   = 24;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned HOUR_W   = 5;
    localparam int unsigned MINUTE_W = 6;
    localparam int unsigned SECOND_W = 6;

    localparam int unsigned YEAR_LSB   = 0;
    localparam int unsigned MONTH_LSB  = YEAR_LSB + YEAR_W;
    localparam int unsigned DAY_LSB    = MONTH_LSB + MONTH_W;
    localparam int unsigned HOUR_LSB   = DAY_LSB + DAY_W;
    localparam int unsigned MINUTE_LSB = HOUR_LSB + HOUR_W;
    localparam int unsigned SECOND_LSB = MINUTE_LSB + MINUTE_W;
    localparam int unsigned FIELDS_W   = SECOND_LSB + SECOND_W;

    localparam int unsigned S_TDATA_W = ((SECS_W + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W = ((FIELDS_W + 7) / 8) * 8;

    // first day of each month within a march-based year
    function automatic logic [8:0] month_start(input logic [3:0] mpos);
        logic [8:0] start;
        unique case (mpos)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

@@ sv/epoch_to_civil_datetime_top.sv @@
// epoch to civil datetime converter, top level
//
// slave side takes one word per signed 48-bit count of seconds since
// 1970-01-01 00:00:00 utc; master side returns the proleptic gregorian
// year, month, day, hour, minute and second of that instant.
// the converter is a 12-register pipeline: input register, ten stages of
// constant-reciprocal divides and corrections, and the output register.
// throughput is one word per cycle while the master side is not stalled.
// every stage advances when it is empty or the stage after it advances, so
// when the receiver stalls the pipeline keeps filling its bubbles and the
// slave side stays ready until all twelve registers hold words.
// reset clears only the valid bits: no word is presented after reset and
// the slave side is ready in the first cycle.
module epoch_to_civil_datetime_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // epoch_seconds
    input  logic [e2cd_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // year, month, day, hour, minute, second, zero pad
    output logic [e2cd_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);

    localparam int unsigned N_STG = 12;
    localparam int unsigned PAD_W = e2cd_pkg::M_TDATA_W - e2cd_pkg::FIELDS_W;

    localparam logic [41:0] SECS_BIAS = 42'(64'd675 << 31);
    localparam logic [15:0] CYC_OFS   = 16'd16384;
    localparam logic [31:0] DAY_BIAS  =
        32'(64'd719468 + 64'd146097 * 64'd16384 - 64'd2147483648);

    localparam logic [21:0] M_HI    = 22'(((64'd1 << 31) + 64'd674) / 64'd675);
    localparam logic [31:0] M_LO    = 32'(((64'd1 << 41) + 64'd674) / 64'd675);
    localparam logic [32:0] M_CYC   = 33'(((64'd1 << 50) + 64'd146096) / 64'd146097);
    localparam logic [17:0] M_HR    = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
    localparam logic [12:0] M_MIN   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
    localparam logic [18:0] M_1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] M_36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] M_365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  M_100   = 10'(((64'd1 << 16) + 64'd99) / 64'd100);

    localparam logic [3:0] MPOS_JAN = 4'd10;

    logic [N_STG-1:0] r_vld;
    logic [N_STG-1:0] w_en;

    // stage registers
    logic [47:0] r_secs_s0;
    logic [11:0] r_qh_s1;
    logic [20:0] r_uh_s1;
    logic [20:0] r_ul_s1;
    logic [6:0]  r_r7_s1;
    logic [30:0] r_x2_s2;
    logic [11:0] r_qh_s2;
    logic [6:0]  r_r7_s2;
    logic [20:0] r_q2_s3;
    logic [30:0] r_x2_s3;
    logic [11:0] r_qh_s3;
    logic [6:0]  r_r7_s3;
    logic [31:0] r_v_s4;
    logic [16:0] r_tod_s4;
    logic [14:0] r_cq_s5;
    logic [31:0] r_v_s5;
    logic [4:0]  r_hh_s5;
    logic [16:0] r_tod_s5;
    logic [17:0] r_dic_s6;
    logic [15:0] r_cyc_s6;
    logic [4:0]  r_hh_s6;
    logic [11:0] r_rem_s6;
    logic [17:0] r_dic_s7;
    logic [6:0]  r_a_s7;
    logic [2:0]  r_b_s7;
    logic        r_c_s7;
    logic [15:0] r_cyc_s7;
    logic [4:0]  r_hh_s7;
    logic [5:0]  r_mm_s7;
    logic [11:0] r_rem_s7;
    logic [17:0] r_t_s8;
    logic [17:0] r_dic_s8;
    logic [15:0] r_cyc_s8;
    logic [4:0]  r_hh_s8;
    logic [5:0]  r_mm_s8;
    logic [5:0]  r_ss_s8;
    logic [8:0]  r_yic_s9;
    logic [17:0] r_dic_s9;
    logic [15:0] r_cyc_s9;
    logic [4:0]  r_hh_s9;
    logic [5:0]  r_mm_s9;
    logic [5:0]  r_ss_s9;
    logic [8:0]  r_diy_s10;
    logic [23:0] r_ybase_s10;
    logic [4:0]  r_hh_s10;
    logic [5:0]  r_mm_s10;
    logic [5:0]  r_ss_s10;
    logic [e2cd_pkg::YEAR_W-1:0]   r_year_s11;
    logic [e2cd_pkg::MONTH_W-1:0]  r_month_s11;
    logic [e2cd_pkg::DAY_W-1:0]    r_day_s11;
    logic [e2cd_pkg::HOUR_W-1:0]   r_hour_s11;
    logic [e2cd_pkg::MINUTE_W-1:0] r_minute_s11;
    logic [e2cd_pkg::SECOND_W-1:0] r_second_s11;

    // next values
    logic [11:0] n_qh_s1;
    logic [30:0] n_x2_s2;
    logic [20:0] n_q2_s3;
    logic [31:0] n_v_s4;
    logic [16:0] n_tod_s4;
    logic [14:0] n_cq_s5;
    logic [4:0]  n_hh_s5;
    logic [17:0] n_dic_s6;
    logic [15:0] n_cyc_s6;
    logic [11:0] n_rem_s6;
    logic [6:0]  n_a_s7;
    logic [2:0]  n_b_s7;
    logic        n_c_s7;
    logic [5:0]  n_mm_s7;
    logic [17:0] n_t_s8;
    logic [5:0]  n_ss_s8;
    logic [8:0]  n_yic_s9;
    logic [8:0]  n_diy_s10;
    logic [23:0] n_ybase_s10;
    logic [e2cd_pkg::YEAR_W-1:0]  n_year_s11;
    logic [e2cd_pkg::MONTH_W-1:0] n_month_s11;
    logic [e2cd_pkg::DAY_W-1:0]   n_day_s11;

    // combinational intermediates
    logic [41:0] w_u;
    logic [42:0] w_hi_prod;
    logic [20:0] w_rh;
    logic [62:0] w_lo_prod;
    logic [30:0] w_r2;
    logic [64:0] w_cyc_prod;
    logic [34:0] w_hr_prod;
    logic [31:0] w_dic_full;
    logic [16:0] w_rem_full;
    logic [36:0] w_d1460_prod;
    logic [36:0] w_d36524_prod;
    logic [24:0] w_min_prod;
    logic [11:0] w_ss_full;
    logic [36:0] w_y365_prod;
    logic [18:0] w_y100_prod;
    logic [17:0] w_soy;
    logic [17:0] w_diy_full;
    logic [3:0]  w_mpos;
    logic [8:0]  w_dom;

    // stage enables: a stage moves when empty or when the next one moves
    always_comb begin
        w_en[N_STG-1] = !r_vld[N_STG-1] || i_m_axis_tready;
        for (int k = N_STG - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < N_STG; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_comb begin
        // split seconds into a biased count of 128 s units, then divide by 675
        w_u       = {r_secs_s0[47], r_secs_s0[47:7]} + SECS_BIAS;
        w_hi_prod = {22'd0, w_u[41:21]} * {21'd0, M_HI};
        n_qh_s1   = w_hi_prod[42:31];

        w_rh    = r_uh_s1 - ({9'd0, r_qh_s1} * 21'd675);
        n_x2_s2 = {w_rh[9:0], r_ul_s1};

        w_lo_prod = {32'd0, r_x2_s2} * {31'd0, M_LO};
        n_q2_s3   = w_lo_prod[61:41];

        w_r2     = r_x2_s3 - ({10'd0, r_q2_s3} * 31'd675);
        n_tod_s4 = {w_r2[9:0], r_r7_s3};
        n_v_s4   = {r_qh_s3[10:0], r_q2_s3} + DAY_BIAS;

        // 400-year cycles and hours
        w_cyc_prod = {33'd0, r_v_s4} * {32'd0, M_CYC};
        n_cq_s5    = w_cyc_prod[64:50];
        w_hr_prod  = {18'd0, r_tod_s4} * {17'd0, M_HR};
        n_hh_s5    = w_hr_prod[33:29];

        w_dic_full = r_v_s5 - ({17'd0, r_cq_s5} * 32'd146097);
        n_dic_s6   = w_dic_full[17:0];
        n_cyc_s6   = {1'b0, r_cq_s5} - CYC_OFS;
        w_rem_full = r_tod_s5 - ({12'd0, r_hh_s5} * 17'd3600);
        n_rem_s6   = w_rem_full[11:0];

        // leap corrections within the cycle, minutes
        w_d1460_prod  = {19'd0, r_dic_s6} * {18'd0, M_1460};
        n_a_s7        = w_d1460_prod[35:29];
        w_d36524_prod = {19'd0, r_dic_s6} * {18'd0, M_36524};
        n_b_s7        = w_d36524_prod[36:34];
        n_c_s7        = (r_dic_s6 == 18'd146096);
        w_min_prod    = {13'd0, r_rem_s6} * {12'd0, M_MIN};
        n_mm_s7       = w_min_prod[23:18];

        n_t_s8    = r_dic_s7 - {11'd0, r_a_s7} + {15'd0, r_b_s7} - {17'd0, r_c_s7};
        w_ss_full = r_rem_s7 - ({6'd0, r_mm_s7} * 12'd60);
        n_ss_s8   = w_ss_full[5:0];

        w_y365_prod = {19'd0, r_t_s8} * {18'd0, M_365};
        n_yic_s9    = w_y365_prod[35:27];

        // day of the march-based year and the cycle's base year
        w_y100_prod = {10'd0, r_yic_s9} * {9'd0, M_100};
        w_soy       = ({9'd0, r_yic_s9} * 18'd365) + {11'd0, r_yic_s9[8:2]}
                    - {16'd0, w_y100_prod[17:16]};
        w_diy_full  = r_dic_s9 - w_soy;
        n_diy_s10   = w_diy_full[8:0];
        n_ybase_s10 = ({{8{r_cyc_s9[15]}}, r_cyc_s9} * 24'd400) + {15'd0, r_yic_s9};

        // month by comparing against month starts
        w_mpos = 4'd0;
        for (int k = 1; k < 12; k++) begin
            if (r_diy_s10 >= e2cd_pkg::month_start(4'(k))) begin
                w_mpos = w_mpos + 4'd1;
            end
        end
        w_dom       = r_diy_s10 - e2cd_pkg::month_start(w_mpos) + 9'd1;
        n_day_s11   = w_dom[4:0];
        n_month_s11 = (w_mpos < MPOS_JAN) ? w_mpos + 4'd3 : w_mpos - 4'd9;
        n_year_s11  = r_ybase_s10 + {23'd0, (w_mpos >= MPOS_JAN)};
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_secs_s0 <= i_s_axis_tdata[e2cd_pkg::SECS_W-1:0];
        end
        if (w_en[1]) begin
            r_qh_s1 <= n_qh_s1;
            r_uh_s1 <= w_u[41:21];
            r_ul_s1 <= w_u[20:0];
            r_r7_s1 <= r_secs_s0[6:0];
        end
        if (w_en[2]) begin
            r_x2_s2 <= n_x2_s2;
            r_qh_s2 <= r_qh_s1;
            r_r7_s2 <= r_r7_s1;
        end
        if (w_en[3]) begin
            r_q2_s3 <= n_q2_s3;
            r_x2_s3 <= r_x2_s2;
            r_qh_s3 <= r_qh_s2;
            r_r7_s3 <= r_r7_s2;
        end
        if (w_en[4]) begin
            r_v_s4   <= n_v_s4;
            r_tod_s4 <= n_tod_s4;
        end
        if (w_en[5]) begin
            r_cq_s5  <= n_cq_s5;
            r_v_s5   <= r_v_s4;
            r_hh_s5  <= n_hh_s5;
            r_tod_s5 <= r_tod_s4;
        end
        if (w_en[6]) begin
            r_dic_s6 <= n_dic_s6;
            r_cyc_s6 <= n_cyc_s6;
            r_hh_s6  <= r_hh_s5;
            r_rem_s6 <= n_rem_s6;
        end
        if (w_en[7]) begin
            r_dic_s7 <= r_dic_s6;
            r_a_s7   <= n_a_s7;
            r_b_s7   <= n_b_s7;
            r_c_s7   <= n_c_s7;
            r_cyc_s7 <= r_cyc_s6;
            r_hh_s7  <= r_hh_s6;
            r_mm_s7  <= n_mm_s7;
            r_rem_s7 <= r_rem_s6;
        end
        if (w_en[8]) begin
            r_t_s8   <= n_t_s8;
            r_dic_s8 <= r_dic_s7;
            r_cyc_s8 <= r_cyc_s7;
            r_hh_s8  <= r_hh_s7;
            r_mm_s8  <= r_mm_s7;
            r_ss_s8  <= n_ss_s8;
        end
        if (w_en[9]) begin
            r_yic_s9 <= n_yic_s9;
            r_dic_s9 <= r_dic_s8;
            r_cyc_s9 <= r_cyc_s8;
            r_hh_s9  <= r_hh_s8;
            r_mm_s9  <= r_mm_s8;
            r_ss_s9  <= r_ss_s8;
        end
        if (w_en[10]) begin
            r_diy_s10   <= n_diy_s10;
            r_ybase_s10 <= n_ybase_s10;
            r_hh_s10    <= r_hh_s9;
            r_mm_s10    <= r_mm_s9;
            r_ss_s10    <= r_ss_s9;
        end
        if (w_en[11]) begin
            r_year_s11   <= n_year_s11;
            r_month_s11  <= n_month_s11;
            r_day_s11    <= n_day_s11;
            r_hour_s11   <= r_hh_s10;
            r_minute_s11 <= r_mm_s10;
            r_second_s11 <= r_ss_s10;
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[N_STG-1];
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_second_s11, r_minute_s11, r_hour_s11,
                              r_day_s11, r_month_s11, r_year_s11};

endmodule

@@ sv/e2cd_chk.sv @@
// port-level checker for the epoch to civil datetime converter, with its bind
module e2cd_chk (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic [e2cd_pkg::S_TDATA_W-1:0]  i_s_axis_tdata,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [e2cd_pkg::M_TDATA_W-1:0]  o_m_axis_tdata
);

    logic [e2cd_pkg::MONTH_W-1:0]  w_month;
    logic [e2cd_pkg::DAY_W-1:0]    w_day;
    logic [e2cd_pkg::HOUR_W-1:0]   w_hour;
    logic [e2cd_pkg::MINUTE_W-1:0] w_minute;
    logic [e2cd_pkg::SECOND_W-1:0] w_second;

    assign w_month  = o_m_axis_tdata[e2cd_pkg::MONTH_LSB +: e2cd_pkg::MONTH_W];
    assign w_day    = o_m_axis_tdata[e2cd_pkg::DAY_LSB +: e2cd_pkg::DAY_W];
    assign w_hour   = o_m_axis_tdata[e2cd_pkg::HOUR_LSB +: e2cd_pkg::HOUR_W];
    assign w_minute = o_m_axis_tdata[e2cd_pkg::MINUTE_LSB +: e2cd_pkg::MINUTE_W];
    assign w_second = o_m_axis_tdata[e2cd_pkg::SECOND_LSB +: e2cd_pkg::SECOND_W];

    // nothing is presented right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_axis_tvalid)
        else $error("word presented after reset");

    // a stalled word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled word changed");

    // an empty or draining output never blocks the slave side
    a_ready_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid || i_m_axis_tready |-> o_s_axis_tready)
        else $error("slave side blocked while output drains");

    // every presented month, hour, minute and second is in range, and the day is at least 1
    a_fields_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> w_month >= 4'd1 && w_month <= 4'd12 && w_day >= 5'd1
            && w_hour <= 5'd23 && w_minute <= 6'd59 && w_second <= 6'd59)
        else $error("field out of range");

endmodule

bind epoch_to_civil_datetime_top e2cd_chk u_e2cd_chk (.*);

@@ verif/e2cd_checker.sv @@
// checker for the epoch to civil datetime converter: predicts every conversion and compares results
module e2cd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [e2cd_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [e2cd_pkg::M_TDATA_W-1:0] i_m_tdata,
    output int unsigned                    o_fail_count,
    output int unsigned                    o_pending,
    output int unsigned                    o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint DAY_SECS     = 86400;
    localparam longint HOUR_SECS    = 3600;
    localparam longint MINUTE_SECS  = 60;
    localparam longint MARCH_OFFSET = 719468;
    localparam longint ERA_DAYS     = 146097;
    localparam longint ERA_YEARS    = 400;
    localparam int unsigned MAX_REPORTS = 60;

    typedef struct packed {
        logic [e2cd_pkg::YEAR_W-1:0]   year;
        logic [e2cd_pkg::MONTH_W-1:0]  month;
        logic [e2cd_pkg::DAY_W-1:0]    day;
        logic [e2cd_pkg::HOUR_W-1:0]   hour;
        logic [e2cd_pkg::MINUTE_W-1:0] minute;
        logic [e2cd_pkg::SECOND_W-1:0] second;
    } t_civil;

    typedef struct {
        logic [e2cd_pkg::SECS_W-1:0] secs;
        t_civil                      date;
    } t_awaited;

    t_awaited    awaited_q[$];
    int unsigned fail_count    = 0;
    int unsigned pending_cnt   = 0;
    int unsigned checked_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_cnt;
    assign o_checked    = checked_count;

    function automatic longint floor_quot(input longint num, input longint den);
        longint q;
        q = num / den;
        if ((num % den) < 0) begin
            q = q - 1;
        end
        return q;
    endfunction

    function automatic t_civil civil_of_epoch(input logic [e2cd_pkg::SECS_W-1:0] raw);
        longint secs, days, tod, shifted, era;
        longint day_of_era, year_of_era, day_of_year, mar_month, mday, mon, yr;
        longint hh, mi, ss;
        t_civil c;
        secs        = longint'($signed(raw));
        days        = floor_quot(secs, DAY_SECS);
        tod         = secs - days * DAY_SECS;
        shifted     = days + MARCH_OFFSET;
        era         = floor_quot(shifted, ERA_DAYS);
        day_of_era  = shifted - era * ERA_DAYS;
        year_of_era = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                       - day_of_era / 146096) / 365;
        day_of_year = day_of_era - (365 * year_of_era + year_of_era / 4 - year_of_era / 100);
        mar_month   = (5 * day_of_year + 2) / 153;
        mday        = day_of_year - (153 * mar_month + 2) / 5 + 1;
        mon         = (mar_month < 10) ? mar_month + 3 : mar_month - 9;
        yr          = year_of_era + era * ERA_YEARS + ((mon <= 2) ? 1 : 0);
        hh          = tod / HOUR_SECS;
        mi          = (tod % HOUR_SECS) / MINUTE_SECS;
        ss          = tod % MINUTE_SECS;
        c.year   = yr[e2cd_pkg::YEAR_W-1:0];
        c.month  = mon[e2cd_pkg::MONTH_W-1:0];
        c.day    = mday[e2cd_pkg::DAY_W-1:0];
        c.hour   = hh[e2cd_pkg::HOUR_W-1:0];
        c.minute = mi[e2cd_pkg::MINUTE_W-1:0];
        c.second = ss[e2cd_pkg::SECOND_W-1:0];
        return c;
    endfunction

    function automatic t_civil unpack_civil(input logic [e2cd_pkg::M_TDATA_W-1:0] w);
        t_civil c;
        c.year   = w[e2cd_pkg::YEAR_LSB +: e2cd_pkg::YEAR_W];
        c.month  = w[e2cd_pkg::MONTH_LSB +: e2cd_pkg::MONTH_W];
        c.day    = w[e2cd_pkg::DAY_LSB +: e2cd_pkg::DAY_W];
        c.hour   = w[e2cd_pkg::HOUR_LSB +: e2cd_pkg::HOUR_W];
        c.minute = w[e2cd_pkg::MINUTE_LSB +: e2cd_pkg::MINUTE_W];
        c.second = w[e2cd_pkg::SECOND_LSB +: e2cd_pkg::SECOND_W];
        return c;
    endfunction

    // log is capped, the count is not
    task automatic report_mismatch(input string what);
        if (fail_count < MAX_REPORTS) begin
            $display("[%0t] mismatch: %s", $time, what);
        end
        fail_count++;
    endtask

    task automatic check_field(input string name, input longint got, input longint want,
                               input logic [e2cd_pkg::SECS_W-1:0] secs);
        if (got != want) begin
            report_mismatch($sformatf("%s for %0d s: got %0d, expected %0d",
                                      name, $signed(secs), got, want));
        end
    endtask

    always @(posedge i_clk) begin
        t_awaited want;
        t_civil   got;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                got = unpack_civil(i_m_tdata);
                checked_count <= checked_count + 1;
                if (awaited_q.size() == 0) begin
                    report_mismatch("result word with no timestamp outstanding");
                end else begin
                    want = awaited_q.pop_front();
                    check_field("year", longint'($signed(got.year)),
                                longint'($signed(want.date.year)), want.secs);
                    check_field("month", longint'(got.month),
                                longint'(want.date.month), want.secs);
                    check_field("day", longint'(got.day),
                                longint'(want.date.day), want.secs);
                    check_field("hour", longint'(got.hour),
                                longint'(want.date.hour), want.secs);
                    check_field("minute", longint'(got.minute),
                                longint'(want.date.minute), want.secs);
                    check_field("second", longint'(got.second),
                                longint'(want.date.second), want.secs);
                    check_field("pad bits", longint'(i_m_tdata >> e2cd_pkg::FIELDS_W),
                                longint'(0), want.secs);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want.secs = i_s_tdata[e2cd_pkg::SECS_W-1:0];
                want.date = civil_of_epoch(i_s_tdata[e2cd_pkg::SECS_W-1:0]);
                awaited_q.push_back(want);
            end
        end
        pending_cnt <= awaited_q.size();
    end

endmodule

@@ verif/tb_epoch_to_civil_datetime_top.sv @@
// testbench top for the epoch to civil datetime converter: stimulus, handshake pacing and verdict
module tb_epoch_to_civil_datetime_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_CYCLES = 300;
    localparam int unsigned N_CORNERS    = 23;

    logic                           clk;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [e2cd_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [e2cd_pkg::M_TDATA_W-1:0] m_tdata;

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    int unsigned tx_idle_pct  = 0;
    int unsigned rx_idle_pct  = 0;
    int unsigned stall_reqs   = 0;
    int unsigned n_sent       = 0;
    int unsigned n_pre_epoch  = 0;

    longint corner_secs [0:N_CORNERS-1] = '{
        0, -1, 1, 86399, 86400, -86400, -86401,
        64'sd140737488355327, -64'sd140737488355328,
        64'sd946684800, 64'sd951782400, 64'sd951868799, 64'sd951868800,
        -64'sd2203891201, -64'sd2203891200,
        -64'sd62167219201, -64'sd62167219200, -64'sd62162121600,
        64'sd253402300799, 64'sd2147483647, 64'sd2147483648,
        64'sh0000_5555_5555_5555, 64'sh0000_AAAA_AAAA_AAAA
    };

    epoch_to_civil_datetime_top dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    e2cd_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial clk = 1'b0;
    always begin
        #4ns clk = 1'b1;
        #4ns clk = 1'b0;
    end

    initial begin
        #2ms;
        $display("timeout with %0d results outstanding", pending);
        $display("simulation failed");
        $finish;
    end

    // receiver pacing, with long holds on request
    initial begin : receiver
        int unsigned hold_left;
        int unsigned stalls_seen;
        hold_left   = 0;
        stalls_seen = 0;
        m_tready    = 1'b0;
        forever begin
            @(posedge clk);
            if (stall_reqs != stalls_seen) begin
                stalls_seen = stall_reqs;
                hold_left   = STALL_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [e2cd_pkg::SECS_W-1:0] random_timestamp();
        longint r, days, secs;
        r = {$urandom(), $urandom()};
        case ($urandom_range(3))
            0: secs = r;
            // within a few centuries of the epoch
            1: secs = r >>> 30;
            // whole-day boundaries, or a random time within the day
            2: begin
                days = r >>> 43;
                case ($urandom_range(2))
                    0: secs = days * 86400;
                    1: secs = days * 86400 + 86399;
                    default: secs = days * 86400 + longint'($urandom_range(86399));
                endcase
            end
            // around the start of a 400-year era
            default: begin
                days = (longint'($urandom_range(16000)) - 8000) * 146097 - 719468
                       + longint'($urandom_range(800)) - 400;
                secs = days * 86400 + longint'($urandom_range(86399));
            end
        endcase
        return secs[e2cd_pkg::SECS_W-1:0];
    endfunction

    task automatic send_word(input logic [e2cd_pkg::SECS_W-1:0] secs);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= secs;
        @(posedge clk);
        while (!s_tready) begin
            @(posedge clk);
        end
        n_sent++;
        if (secs[e2cd_pkg::SECS_W-1]) begin
            n_pre_epoch++;
        end
    endtask

    task automatic send_random(input int unsigned count);
        repeat (count) begin
            send_word(random_timestamp());
        end
    endtask

    initial begin : stimulus
        longint c;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        rst_n    = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 24;
        rx_idle_pct <= 78;
        foreach (corner_secs[k]) begin
            c = corner_secs[k];
            send_word(c[e2cd_pkg::SECS_W-1:0]);
        end
        stall_reqs <= stall_reqs + 1;
        send_random(330);

        tx_idle_pct = 78;
        rx_idle_pct <= 24;
        send_random(350);

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        stall_reqs <= stall_reqs + 1;
        send_random(400);

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (24) @(posedge clk);

        $display("covered %0d timestamps (%0d before 1970, corners included), %0d results compared",
                 n_sent, n_pre_epoch, checked);
        $display("pacing: idle 24/78, 78/24 and none, plus two %0d-cycle output holds",
                 STALL_CYCLES);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
sv/e2cd_pkg.sv
sv/epoch_to_civil_datetime_top.sv
sv/e2cd_chk.sv
verif/e2cd_checker.sv
verif/tb_epoch_to_civil_datetime_top.sv
